// File: hdl/framed_command_receiver_macros.svh
// ----------------------------------------------------------------------------
// Framed command receiver: assertion macros
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_RECEIVER_MACROS_SVH
`define FRAMED_COMMAND_RECEIVER_MACROS_SVH

// Same-cycle implication, muted during reset.
`define FCR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framed_command_receiver: same-cycle check failed");

// Next-cycle implication, muted during reset.
`define FCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framed_command_receiver: next-cycle check failed");

// Next-cycle implication that also watches reset itself.
`define FCR_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("framed_command_receiver: reset check failed");

`endif

// File: hdl/fcr_pkg.sv
// ----------------------------------------------------------------------------
// Framed command receiver: package
// Codes, reset values and the result item type.
// ----------------------------------------------------------------------------
package fcr_pkg;

  localparam int PACKET_BYTES_DEFAULT = 16;

  // Item opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam int  CFG_INDEX_W = 1;
  localparam int  CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MARKER  = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [7:0]  MARKER_RESET  = 8'hF0;
  localparam logic [7:0]  SUM_GOOD      = 8'hFF;

  typedef struct packed {
    logic [15:0] throttle;
    logic [7:0]  enable_value;
    logic        packet_good;
    logic        packet_bad;
    logic        timed_out;
  } result_t;

endpackage

// File: hdl/fcr_interfaces.sv
// ----------------------------------------------------------------------------
// Framed command receiver: channel interfaces
// Valid/ready channels for items in, results out and register writes.
// ----------------------------------------------------------------------------
interface fcr_cmd_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface fcr_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] throttle;
  logic [7:0]  enable_value;
  logic        packet_good;
  logic        packet_bad;
  logic        timed_out;

  modport source (output valid, output throttle, output enable_value, output packet_good,
                  output packet_bad, output timed_out, input ready);
  modport sink   (input valid, input throttle, input enable_value, input packet_good,
                  input packet_bad, input timed_out, output ready);
endinterface

interface fcr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fcr_pkg::CFG_INDEX_W-1:0] index;
  logic [fcr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/framed_command_receiver.sv
// ----------------------------------------------------------------------------
// Framed command receiver: top level
// Results are registered in the output register, or in the skid slot on a stall.
// Throughput: one item per cycle while the skid slot is free, set by fcr_core.
// A two-slot output (result register plus skid) takes one more item under a stall.
// Reset (rst, synchronous): hunting, sums, held values and silence count zero,
// timeout 500 ticks, start marker 0xF0, no result pending.
// ----------------------------------------------------------------------------
module framed_command_receiver #(
  parameter int PACKET_BYTES = fcr_pkg::PACKET_BYTES_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  fcr_cmd_if.sink      cmd,
  fcr_result_if.source result,
  fcr_cfg_if.sink      cfg
);

  // Configuration registers; user must write only while idle; no interlock enforces it.
  logic [15:0] timeout_ticks;
  logic [7:0]  start_marker;

  // Output register and skid slot
  logic             out_valid;
  fcr_pkg::result_t out_item;
  logic             skid_valid;
  fcr_pkg::result_t skid_item;

  logic             accept;
  fcr_pkg::result_t step_result;

  // Ready drops only when the skid slot is taken; a waiting result alone
  // never blocks the next item.
  assign cmd.ready = !skid_valid;
  assign accept    = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= fcr_pkg::TIMEOUT_RESET;
      start_marker  <= fcr_pkg::MARKER_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fcr_pkg::REG_TIMEOUT: timeout_ticks <= cfg.data;
        fcr_pkg::REG_MARKER:  start_marker  <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Framing, checksum and silence timer: state advances on every taken item.
  fcr_core #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .opcode       (cmd.opcode),
    .rx_byte      (cmd.rx_byte),
    .timeout_ticks(timeout_ticks),
    .start_marker (start_marker),
    .result       (step_result)
  );

  // Result delivery: the skid slot drains first so order is kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (accept) begin
        out_item <= step_result;
      end
    end else if (accept) begin
      skid_item <= step_result;
    end
  end

  assign result.valid        = out_valid;
  assign result.throttle     = out_item.throttle;
  assign result.enable_value = out_item.enable_value;
  assign result.packet_good  = out_item.packet_good;
  assign result.packet_bad   = out_item.packet_bad;
  assign result.timed_out    = out_item.timed_out;

endmodule

// File: hdl/fcr_core.sv
// ----------------------------------------------------------------------------
// Framed command receiver: frame and timeout engine
// Holds the framing state and works one item per enabled cycle.
// ----------------------------------------------------------------------------
module fcr_core #(
  parameter int PACKET_BYTES = fcr_pkg::PACKET_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             opcode,
  input  logic [7:0]       rx_byte,
  input  logic [15:0]      timeout_ticks,
  input  logic [7:0]       start_marker,
  output fcr_pkg::result_t result
);

  localparam int POS_W = $clog2(PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_HUNT = '0;
  localparam logic [POS_W-1:0] POS_LO   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HI   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_EN   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);

  logic [POS_W-1:0] position, position_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [15:0]      pending_throttle, pending_throttle_next;
  logic [7:0]       pending_enable, pending_enable_next;
  logic [15:0]      held_throttle, held_throttle_next;
  logic [7:0]       held_enable, held_enable_next;
  logic [15:0]      silence_ticks, silence_ticks_next;
  logic [7:0]       sum_add;
  logic             good, bad, timed;

  assign sum_add = running_sum + rx_byte;

  always_comb begin
    position_next         = position;
    running_sum_next      = running_sum;
    pending_throttle_next = pending_throttle;
    pending_enable_next   = pending_enable;
    held_throttle_next    = held_throttle;
    held_enable_next      = held_enable;
    silence_ticks_next    = silence_ticks;
    good                  = 1'b0;
    bad                   = 1'b0;

    if (opcode == fcr_pkg::OP_TICK) begin
      if (silence_ticks < timeout_ticks) begin
        silence_ticks_next = silence_ticks + 16'd1;
      end
    end else if (position == POS_HUNT) begin
      if (rx_byte == start_marker) begin
        running_sum_next = rx_byte;
        position_next    = POS_LO;
      end
    end else begin
      running_sum_next = sum_add;
      case (position)
        POS_LO:  pending_throttle_next[7:0]  = rx_byte;
        POS_HI:  pending_throttle_next[15:8] = rx_byte;
        POS_EN:  pending_enable_next         = rx_byte;
        default: ;
      endcase
      if (position == POS_LAST) begin
        position_next = POS_HUNT;
        if (sum_add == fcr_pkg::SUM_GOOD) begin
          // pending values taken after this byte: a short frame ends on the enable byte
          held_throttle_next = pending_throttle_next;
          held_enable_next   = pending_enable_next;
          silence_ticks_next = '0;
          good               = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end else begin
        position_next = position + POS_W'(1);
      end
    end

    timed = silence_ticks_next >= timeout_ticks;
    if (timed) begin
      held_throttle_next = '0;
      held_enable_next   = '0;
    end
  end

  always_comb begin
    result.throttle     = held_throttle_next;
    result.enable_value = held_enable_next;
    result.packet_good  = good;
    result.packet_bad   = bad;
    result.timed_out    = timed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= POS_HUNT;
      running_sum      <= '0;
      pending_throttle <= '0;
      pending_enable   <= '0;
      held_throttle    <= '0;
      held_enable      <= '0;
      silence_ticks    <= '0;
    end else if (step) begin
      position         <= position_next;
      running_sum      <= running_sum_next;
      pending_throttle <= pending_throttle_next;
      pending_enable   <= pending_enable_next;
      held_throttle    <= held_throttle_next;
      held_enable      <= held_enable_next;
      silence_ticks    <= silence_ticks_next;
    end
  end

endmodule

// File: hdl/fcr_checker.sv
// ----------------------------------------------------------------------------
// Framed command receiver: port checker
// Watches the top-level result channel over time.
// ----------------------------------------------------------------------------
`include "framed_command_receiver_macros.svh"

module fcr_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] throttle,
  input logic [7:0]  enable_value,
  input logic        packet_good,
  input logic        packet_bad,
  input logic        timed_out
);

  // a frame ends either good or bad, never both
  `FCR_ASSERT_NOW(a_good_bad_excl, out_valid, !(packet_good && packet_bad))

  // timed out means held values cleared
  `FCR_ASSERT_NOW(a_timeout_clears, out_valid && timed_out,
                  throttle == 16'd0 && enable_value == 8'd0)

  // nothing offered right after reset
  `FCR_ASSERT_RESET(a_reset_empty, rst, !out_valid)

  // a stalled result holds
  `FCR_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
                   out_valid && $stable(throttle) && $stable(enable_value) &&
                   $stable(packet_good) && $stable(packet_bad) && $stable(timed_out))

endmodule

bind framed_command_receiver fcr_port_checker u_fcr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .throttle    (result.throttle),
  .enable_value(result.enable_value),
  .packet_good (result.packet_good),
  .packet_bad  (result.packet_bad),
  .timed_out   (result.timed_out)
);
